### hw/rtl/assert_macros.svh
// Assertion macros shared by the calendar clock RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hw/rtl/cca_pkg.sv
// Package for the calendar clock: constants, sequencer types, microcode ROM
// and calendar helper functions. No dependencies.
package cca_pkg;

    localparam int ADVANCE_BITS_DEF = 20;

    localparam logic [11:0] YEAR_RST     = 12'd2012;
    localparam logic [11:0] MAX_YEAR_RST = 12'd2050;
    localparam logic [4:0]  ROLL_HR_RST  = 5'd6;
    localparam logic [4:0]  LAST_HOUR    = 5'd23;

    // n/15 and n/3 by reciprocal, exact for any 32-bit n
    localparam logic [31:0] RECIP_15       = 32'h8888_8889;
    localparam int          RECIP_15_SHIFT = 35;
    localparam logic [31:0] RECIP_3        = 32'hAAAA_AAAB;
    localparam int          RECIP_3_SHIFT  = 33;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLLOVER_HOUR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR      = 1'd1;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
    localparam logic [PC_W-1:0] PC_DSEC  = 4'd2;
    localparam logic [PC_W-1:0] PC_SSEC  = 4'd3;
    localparam logic [PC_W-1:0] PC_DMIN  = 4'd4;
    localparam logic [PC_W-1:0] PC_SMIN  = 4'd5;
    localparam logic [PC_W-1:0] PC_DHR   = 4'd6;
    localparam logic [PC_W-1:0] PC_SHR   = 4'd7;
    localparam logic [PC_W-1:0] PC_DAY   = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;
    localparam logic [PC_W-1:0] PC_DONE  = 4'd10;

    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_ACCEPT,
        ACT_DIV,
        ACT_SEC,
        ACT_MIN,
        ACT_HOUR,
        ACT_DAY,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_IN,
        C_IS_SET,
        C_DAYS_MORE,
        C_OUT_BUSY,
        C_ALWAYS
    } cond_t;

    typedef enum logic {
        DIV_60,
        DIV_24
    } div_sel_t;

    typedef struct packed {
        act_t            act;
        div_sel_t        dsel;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            PC_IDLE:  w = '{ACT_ACCEPT, DIV_60, C_NO_IN,     PC_IDLE};
            PC_CHECK: w = '{ACT_NOP,    DIV_60, C_IS_SET,    PC_EMIT};
            PC_DSEC:  w = '{ACT_DIV,    DIV_60, C_NEVER,     PC_IDLE};
            PC_SSEC:  w = '{ACT_SEC,    DIV_60, C_NEVER,     PC_IDLE};
            PC_DMIN:  w = '{ACT_DIV,    DIV_60, C_NEVER,     PC_IDLE};
            PC_SMIN:  w = '{ACT_MIN,    DIV_60, C_NEVER,     PC_IDLE};
            PC_DHR:   w = '{ACT_DIV,    DIV_24, C_NEVER,     PC_IDLE};
            PC_SHR:   w = '{ACT_HOUR,   DIV_60, C_NEVER,     PC_IDLE};
            PC_DAY:   w = '{ACT_DAY,    DIV_60, C_DAYS_MORE, PC_DAY};
            PC_EMIT:  w = '{ACT_EMIT,   DIV_60, C_OUT_BUSY,  PC_EMIT};
            PC_DONE:  w = '{ACT_NOP,    DIV_60, C_ALWAYS,    PC_IDLE};
            default:  w = '{ACT_NOP,    DIV_60, C_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

    // y/100 by reciprocal, exact for 12-bit years
    function automatic logic is_leap(input logic [11:0] y);
        logic [24:0] prod;
        logic [5:0]  q;
        logic [11:0] back;
        logic        div100;
        prod   = 25'(y) * 25'(5243);
        q      = prod[24:19];
        back   = 12'({q, 6'b0}) + 12'({q, 5'b0}) + 12'({q, 2'b0});
        div100 = (back == y);
        return div100 ? (q[1:0] == 2'b00) : (y[1:0] == 2'b00);
    endfunction

    function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
        logic [4:0] d;
        if (m == 4'd2 && is_leap(y))
        begin
            d = 5'd29;
        end
        else if (m >= 4'd1 && m <= 4'd12)
        begin
            d = MONTH_LEN[m - 4'd1];
        end
        else
        begin
            d = 5'd30;
        end
        return d;
    endfunction

    function automatic logic [2:0] next_weekday(input logic [2:0] w);
        logic [2:0] r;
        case (w)
            3'd6:    r = 3'd0;
            3'd7:    r = 3'd1;
            default: r = w + 3'd1;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/cca_if.sv
// Valid/ready channels of the calendar clock: command in, status out.
// Depends on cca_pkg.
interface cca_in_if #(
    parameter int ADVANCE_BITS = cca_pkg::ADVANCE_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [ADVANCE_BITS-1:0] advance_seconds;
    logic [11:0]             new_year;
    logic [3:0]              new_month;
    logic [4:0]              new_day;
    logic [2:0]              new_weekday;
    logic [4:0]              new_hour;
    logic [5:0]              new_minute;
    logic [5:0]              new_second;

    modport source (
        output valid, op, advance_seconds, new_year, new_month, new_day,
               new_weekday, new_hour, new_minute, new_second,
        input  ready
    );
    modport sink (
        input  valid, op, advance_seconds, new_year, new_month, new_day,
               new_weekday, new_hour, new_minute, new_second,
        output ready
    );
endinterface

interface cca_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year_now;
    logic [3:0]  month_now;
    logic [4:0]  day_now;
    logic [2:0]  weekday_now;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic        rollover;
    logic        rollover_sunday;
    logic [31:0] day_count;

    modport source (
        output valid, year_now, month_now, day_now, weekday_now, hour_now,
               minute_now, second_now, rollover, rollover_sunday, day_count,
        input  ready
    );
    modport sink (
        input  valid, year_now, month_now, day_now, weekday_now, hour_now,
               minute_now, second_now, rollover, rollover_sunday, day_count,
        output ready
    );
endinterface

### hw/rtl/calendar_clock_advance.sv
// Calendar clock top level: microcoded sequencer over a small datapath.
// Depends on cca_pkg, cca_if and assert_macros.svh.
// A set transaction passes from acceptance through the check step to the emit step, which
// writes the status register, and then through the done step back to idle. An advance
// transaction passes through the check step, three reciprocal divisions (by 60, 60 and 24),
// each followed by a store step, then the day stepper, which moves the calendar one day per
// cycle, and then the emit and done steps. One command is in flight at a time; a status
// transaction not yet taken stalls the emit step, and the next command can be accepted once
// the done step has returned to idle after a result is written, whether or not it has been
// taken.
`include "assert_macros.svh"

module calendar_clock_advance #(
    parameter int ADVANCE_BITS = cca_pkg::ADVANCE_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [cca_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [cca_pkg::CFG_DATA_W-1:0]           cfg_wdata,
    cca_in_if.sink                                   cmd,
    cca_out_if.source                                status
);
    import cca_pkg::*;

    localparam int DW = ADVANCE_BITS + 1;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [DW-1:0]   acc_reg, acc_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   days_reg, days_next;
    logic            op_reg, op_next;
    logic            fired_reg, fired_next;
    logic            sunday_reg, sunday_next;

    logic [4:0]  roll_hr_reg;
    logic [11:0] max_year_reg;

    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [2:0]  weekday_reg, weekday_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [31:0] day_cnt_reg, day_cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_load;
    logic [11:0] o_year_reg;
    logic [3:0]  o_month_reg;
    logic [4:0]  o_day_reg;
    logic [2:0]  o_weekday_reg;
    logic [4:0]  o_hour_reg;
    logic [5:0]  o_minute_reg;
    logic [5:0]  o_second_reg;
    logic        o_roll_reg;
    logic        o_sunday_reg;
    logic [31:0] o_day_cnt_reg;

    ucode_t        cw;
    logic          take_jump;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   prod;
    logic [DW-1:0] quo_calc;
    logic [5:0]    rem60;
    logic [4:0]    rem24;
    logic [4:0]    lim;
    logic [4:0]    below;

    assign cmd.ready = (pc_reg == PC_IDLE);

    assign status.valid           = out_valid_reg;
    assign status.year_now        = o_year_reg;
    assign status.month_now       = o_month_reg;
    assign status.day_now         = o_day_reg;
    assign status.weekday_now     = o_weekday_reg;
    assign status.hour_now        = o_hour_reg;
    assign status.minute_now      = o_minute_reg;
    assign status.second_now      = o_second_reg;
    assign status.rollover        = o_roll_reg;
    assign status.rollover_sunday = o_sunday_reg;
    assign status.day_count       = o_day_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_hr_reg  <= ROLL_HR_RST;
            max_year_reg <= MAX_YEAR_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ROLLOVER_HOUR: roll_hr_reg  <= cfg_wdata[4:0];
                CFG_MAX_YEAR:      max_year_reg <= cfg_wdata[11:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cw       = ucode_rom(pc_reg);
        // x/60 = (x/4)/15 and x/24 = (x/8)/3
        mul_a    = (cw.dsel == DIV_24) ? 32'(acc_reg >> 3) : 32'(acc_reg >> 2);
        mul_b    = (cw.dsel == DIV_24) ? RECIP_3 : RECIP_15;
        prod     = {32'b0, mul_a} * {32'b0, mul_b};
        quo_calc = (cw.dsel == DIV_24) ? DW'(prod >> RECIP_3_SHIFT)
                                       : DW'(prod >> RECIP_15_SHIFT);
        // x - 60q = x + 4q mod 64, x - 24q = x + 8q mod 32
        rem60    = acc_reg[5:0] + {quo_reg[3:0], 2'b00};
        rem24    = acc_reg[4:0] + {quo_reg[1:0], 3'b000};
        lim      = month_days(year_reg, month_reg);
        below    = (roll_hr_reg == 5'd0) ? LAST_HOUR : roll_hr_reg - 5'd1;

        case (cw.cond)
            C_NEVER:     take_jump = 1'b0;
            C_NO_IN:     take_jump = !cmd.valid;
            C_IS_SET:    take_jump = op_reg;
            C_DAYS_MORE: take_jump = (days_reg > DW'(1));
            C_OUT_BUSY:  take_jump = out_valid_reg && !status.ready;
            C_ALWAYS:    take_jump = 1'b1;
            default:     take_jump = 1'b0;
        endcase
        pc_next = take_jump ? cw.target : pc_reg + PC_W'(1);

        acc_next       = acc_reg;
        quo_next       = quo_reg;
        days_next      = days_reg;
        op_next        = op_reg;
        fired_next     = fired_reg;
        sunday_next    = sunday_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        weekday_next   = weekday_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        day_cnt_next   = day_cnt_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !status.ready;

        case (cw.act)
            ACT_ACCEPT:
            begin
                if (cmd.valid)
                begin
                    op_next     = cmd.op;
                    fired_next  = 1'b0;
                    sunday_next = 1'b0;
                    if (cmd.op)
                    begin
                        year_next    = cmd.new_year;
                        month_next   = cmd.new_month;
                        day_next     = cmd.new_day;
                        weekday_next = cmd.new_weekday;
                        hour_next    = cmd.new_hour;
                        minute_next  = cmd.new_minute;
                        second_next  = cmd.new_second;
                    end
                    else
                    begin
                        acc_next = DW'(cmd.advance_seconds) + DW'(second_reg);
                    end
                end
            end
            ACT_DIV:
            begin
                quo_next = quo_calc;
            end
            ACT_SEC:
            begin
                second_next = rem60;
                acc_next    = quo_reg + DW'(minute_reg);
            end
            ACT_MIN:
            begin
                minute_next = rem60;
                acc_next    = quo_reg + DW'(hour_reg);
            end
            ACT_HOUR:
            begin
                hour_next = rem24;
                days_next = quo_reg;
                if (roll_hr_reg <= LAST_HOUR && hour_reg == below
                    && rem24 == roll_hr_reg)
                begin
                    fired_next   = 1'b1;
                    day_cnt_next = day_cnt_reg + 32'd1;
                    sunday_next  = (weekday_reg == 3'd0);
                end
            end
            ACT_DAY:
            begin
                if (days_reg != '0)
                begin
                    days_next    = days_reg - DW'(1);
                    weekday_next = next_weekday(weekday_reg);
                    if (day_reg >= lim)
                    begin
                        day_next = 5'd1;
                        if (month_reg >= 4'd12)
                        begin
                            month_next = 4'd1;
                            if ({1'b0, year_reg} + 13'd1 > {1'b0, max_year_reg})
                            begin
                                year_next = max_year_reg;
                            end
                            else
                            begin
                                year_next = year_reg + 12'd1;
                            end
                        end
                        else
                        begin
                            month_next = month_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        day_next = day_reg + 5'd1;
                    end
                end
            end
            ACT_EMIT:
            begin
                if (!out_valid_reg || status.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            days_reg      <= '0;
            op_reg        <= 1'b0;
            fired_reg     <= 1'b0;
            sunday_reg    <= 1'b0;
            year_reg      <= YEAR_RST;
            month_reg     <= 4'd1;
            day_reg       <= 5'd1;
            weekday_reg   <= 3'd0;
            hour_reg      <= 5'd0;
            minute_reg    <= 6'd0;
            second_reg    <= 6'd0;
            day_cnt_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            days_reg      <= days_next;
            op_reg        <= op_next;
            fired_reg     <= fired_next;
            sunday_reg    <= sunday_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            weekday_reg   <= weekday_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            day_cnt_reg   <= day_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        if (out_load)
        begin
            o_year_reg    <= year_reg;
            o_month_reg   <= month_reg;
            o_day_reg     <= day_reg;
            o_weekday_reg <= weekday_reg;
            o_hour_reg    <= hour_reg;
            o_minute_reg  <= minute_reg;
            o_second_reg  <= second_reg;
            o_roll_reg    <= fired_reg;
            o_sunday_reg  <= sunday_reg;
            o_day_cnt_reg <= day_cnt_reg;
        end
    end

    `ASSERT_CLK(a_ready_only_idle, (pc_reg != PC_IDLE) |-> !cmd.ready, "ready outside idle")
    `ASSERT_CLK(a_days_done, (pc_reg == PC_EMIT) |-> (days_reg == '0), "days left at emit")
    `ASSERT_NEVER(a_sun_roll, out_valid_reg && o_sunday_reg && !o_roll_reg, "stray sunday")
    `ASSERT_CLK(a_cnt_hr, (day_cnt_next != day_cnt_reg) |-> (pc_reg == PC_SHR), "stray count")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for calendar_clock_advance: directed and random set/advance transactions,
// checked field by field against a behavioral clock predictor, with stalls on both sides.
// Depends on cca_pkg, the cca_in_if/cca_out_if interfaces and the calendar_clock_advance RTL.
module testbench;
    import cca_pkg::*;

    localparam int ADV_W = ADVANCE_BITS_DEF;
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_SET = 1'b1;
    localparam int SECS_PER_DAY = 86400;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 3 * (ADV_W + 1) + 7 + 24;

    typedef struct packed {
        logic             op;
        logic [ADV_W-1:0] secs;
        logic [11:0]      year;
        logic [3:0]       month;
        logic [4:0]       day;
        logic [2:0]       wday;
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [5:0]       second;
    } clock_cmd_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        fired;
        logic        sunday;
        logic [31:0] count;
    } clock_stat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cca_in_if #(.ADVANCE_BITS(ADV_W)) cmd ();
    cca_out_if status ();

    calendar_clock_advance #(.ADVANCE_BITS(ADV_W)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cmd(cmd),
        .status(status)
    );

    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [2:0]  cal_wday;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;
    logic [31:0] rollovers;
    logic [4:0]  roll_hour;
    logic [11:0] year_limit;

    clock_stat_t expected_status [$];
    int errors = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int hold_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit leap_year_of(input logic [11:0] y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned month_length(input logic [11:0] y, input logic [3:0] m);
        int unsigned len;
        case (m)
            4'd2:                                   len = leap_year_of(y) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11:                len = 30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 31;
            default:                                len = 30;
        endcase
        return len;
    endfunction

    function automatic clock_stat_t predict_status(input clock_cmd_t c);
        clock_stat_t s;
        int unsigned tsec;
        int unsigned tmin;
        int unsigned thr;
        int unsigned days;
        int unsigned below;
        logic [4:0]  prev;
        s.fired = 1'b0;
        s.sunday = 1'b0;
        if (c.op == OP_SET)
        begin
            cal_year = c.year;
            cal_month = c.month;
            cal_day = c.day;
            cal_wday = c.wday;
            cal_hour = c.hour;
            cal_minute = c.minute;
            cal_second = c.second;
        end
        else
        begin
            tsec = cal_second + c.secs;
            tmin = cal_minute + tsec / 60;
            thr = cal_hour + tmin / 60;
            days = thr / 24;
            prev = cal_hour;
            cal_second = 6'(tsec % 60);
            cal_minute = 6'(tmin % 60);
            cal_hour = 5'(thr % 24);
            below = (roll_hour == 5'd0) ? 23 : roll_hour - 1;
            if (roll_hour <= 5'd23 && prev == below && cal_hour == roll_hour)
            begin
                s.fired = 1'b1;
                s.sunday = (cal_wday == 3'd0);
                rollovers = rollovers + 32'd1;
            end
            repeat (days)
            begin
                cal_wday = 3'((cal_wday + 1) % 7);
                if (cal_day >= month_length(cal_year, cal_month))
                begin
                    cal_day = 5'd1;
                    if (cal_month >= 4'd12)
                    begin
                        cal_month = 4'd1;
                        if (cal_year + 1 > year_limit)
                            cal_year = year_limit;
                        else
                            cal_year = cal_year + 12'd1;
                    end
                    else
                    begin
                        cal_month = cal_month + 4'd1;
                    end
                end
                else
                begin
                    cal_day = cal_day + 5'd1;
                end
            end
        end
        s.year = cal_year;
        s.month = cal_month;
        s.day = cal_day;
        s.wday = cal_wday;
        s.hour = cal_hour;
        s.minute = cal_minute;
        s.second = cal_second;
        s.count = rollovers;
        return s;
    endfunction

    function automatic clock_cmd_t advance_item(input int unsigned secs);
        clock_cmd_t c;
        c = clock_cmd_t'({$urandom, $urandom, $urandom});
        c.op = OP_ADVANCE;
        c.secs = ADV_W'(secs);
        return c;
    endfunction

    function automatic clock_cmd_t set_item(input int unsigned y, input int unsigned m,
                                            input int unsigned d, input int unsigned w,
                                            input int unsigned h, input int unsigned mi,
                                            input int unsigned s);
        clock_cmd_t c;
        c.op = OP_SET;
        c.secs = ADV_W'($urandom);
        c.year = 12'(y);
        c.month = 4'(m);
        c.day = 5'(d);
        c.wday = 3'(w);
        c.hour = 5'(h);
        c.minute = 6'(mi);
        c.second = 6'(s);
        return c;
    endfunction

    // well-formed date; month_end picks the last or next-to-last day of the month
    function automatic clock_cmd_t random_set(input bit month_end, input int unsigned h);
        int          yr;
        int unsigned mo;
        int unsigned dy;
        case ($urandom_range(0, 3))
            0:       yr = $urandom_range(0, 4095);
            1:       yr = $urandom_range(0, 40) * 100;
            2:       yr = int'(year_limit) + int'($urandom_range(0, 3)) - 2;
            default: yr = $urandom_range(1990, 2060);
        endcase
        if (yr < 0)
            yr = 0;
        if (yr > 4095)
            yr = 4095;
        if (month_end && $urandom_range(0, 2) == 0)
            mo = 12;
        else
            mo = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
        if (month_end)
            dy = month_length(12'(yr), 4'(mo)) - $urandom_range(0, 1);
        else
            dy = $urandom_range(1, month_length(12'(yr), 4'(mo)));
        return set_item(yr, mo, dy, $urandom_range(0, 6), h,
                        $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    task automatic send_cmd(input clock_cmd_t c);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.op <= c.op;
        cmd.advance_seconds <= c.secs;
        cmd.new_year <= c.year;
        cmd.new_month <= c.month;
        cmd.new_day <= c.day;
        cmd.new_weekday <= c.wday;
        cmd.new_hour <= c.hour;
        cmd.new_minute <= c.minute;
        cmd.new_second <= c.second;
        do @(posedge clk); while (!cmd.ready);
        expected_status.push_back(predict_status(c));
    endtask

    task automatic pause_until_drained();
        cmd.valid <= 1'b0;
        do @(posedge clk); while (expected_status.size() != 0);
    endtask

    // write both registers on back-to-back edges; junk above bit 4 must be dropped
    task automatic write_config(input logic [4:0] hour_sel, input logic [11:0] year_cap);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROLLOVER_HOUR;
        cfg_wdata <= {7'($urandom), hour_sel};
        @(posedge clk);
        cfg_index <= CFG_MAX_YEAR;
        cfg_wdata <= year_cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        roll_hour = hour_sel;
        year_limit = year_cap;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_status(input clock_stat_t got);
        clock_stat_t want;
        if (expected_status.size() == 0)
        begin
            $display("%0t: status transaction with nothing pending: %0d-%0d-%0d %0d:%0d:%0d",
                     $time, got.year, got.month, got.day, got.hour, got.minute, got.second);
            errors++;
        end
        else
        begin
            want = expected_status.pop_front();
            compare_field("year_now", 32'(want.year), 32'(got.year));
            compare_field("month_now", 32'(want.month), 32'(got.month));
            compare_field("day_now", 32'(want.day), 32'(got.day));
            compare_field("weekday_now", 32'(want.wday), 32'(got.wday));
            compare_field("hour_now", 32'(want.hour), 32'(got.hour));
            compare_field("minute_now", 32'(want.minute), 32'(got.minute));
            compare_field("second_now", 32'(want.second), 32'(got.second));
            compare_field("rollover", 32'(want.fired), 32'(got.fired));
            compare_field("rollover_sunday", 32'(want.sunday), 32'(got.sunday));
            compare_field("day_count", want.count, got.count);
        end
    endtask

    task automatic test_reset_values();
        send_cmd(advance_item(0));
        send_cmd(advance_item(5 * 3600));
        send_cmd(advance_item(3600));
    endtask

    task automatic test_field_extremes();
        send_cmd(set_item(4095, 15, 31, 7, 31, 63, 63));
        send_cmd(advance_item(1));
        send_cmd(set_item(0, 0, 0, 0, 0, 0, 0));
        send_cmd(advance_item(SECS_PER_DAY - 1));
        send_cmd(advance_item(1));
        send_cmd(advance_item((1 << ADV_W) - 1));
    endtask

    task automatic test_calendar_rollover();
        send_cmd(set_item(2000, 2, 28, 1, 23, 59, 59));
        send_cmd(advance_item(1));
        send_cmd(set_item(1900, 2, 28, 3, 23, 59, 59));
        send_cmd(advance_item(1));
        send_cmd(set_item(2400, 2, 28, 2, 23, 59, 59));
        send_cmd(advance_item(1));
        send_cmd(set_item(2012, 2, 29, 3, 23, 59, 59));
        send_cmd(advance_item(1));
        send_cmd(set_item(2049, 12, 31, 6, 23, 59, 59));
        send_cmd(advance_item(1));
        send_cmd(set_item(2050, 12, 31, 6, 23, 59, 59));
        send_cmd(advance_item(1));
        send_cmd(set_item(3000, 12, 31, 4, 23, 59, 59));
        send_cmd(advance_item(1));
    endtask

    // hold the status side long enough that the command side backs up
    task automatic test_input_backpressure();
        int n;
        tx_idle = 1'b0;
        hold_cycles = 400;
        for (n = 0; n < 12; n++)
            send_cmd(advance_item($urandom_range(0, 5000)));
        pause_until_drained();
        tx_idle = 1'b1;
    endtask

    task automatic run_random(input int count);
        int          sent;
        int          next_toggle;
        int          kind;
        int unsigned below;
        sent = 0;
        next_toggle = 0;
        while (sent < count)
        begin
            if (sent >= next_toggle)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
                next_toggle = sent + 40;
            end
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                send_cmd(advance_item($urandom_range(0, 3600)));
            end
            else if (kind < 45)
            begin
                send_cmd(advance_item($urandom_range(0, 2 * SECS_PER_DAY)));
            end
            else if (kind < 55)
            begin
                send_cmd(advance_item($urandom));
            end
            else if (kind < 70)
            begin
                // start one hour short of the rollover hour, then advance by up to two hours
                below = (roll_hour == 5'd0) ? 23 : roll_hour - 1;
                send_cmd(random_set(1'b0, below));
                send_cmd(advance_item($urandom_range(1, 7200)));
                sent++;
            end
            else if (kind < 80)
            begin
                send_cmd(random_set(1'b0, $urandom_range(0, 23)));
            end
            else if (kind < 87)
            begin
                send_cmd(set_item($urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom));
            end
            else
            begin
                send_cmd(random_set(1'b1, 23));
                send_cmd(advance_item($urandom_range(0, 3 * SECS_PER_DAY)));
                sent++;
            end
            sent++;
        end
    endtask

    task automatic test_config_sweep();
        int k;
        pause_until_drained();
        write_config(5'd0, 12'd0);
        run_random(100);
        pause_until_drained();
        write_config(5'd23, 12'd4095);
        run_random(120);
        pause_until_drained();
        write_config(5'd31, 12'd2050);
        run_random(80);
        pause_until_drained();
        write_config(ROLL_HR_RST, MAX_YEAR_RST);
        run_random(120);
        for (k = 0; k < 4; k++)
        begin
            pause_until_drained();
            write_config(5'($urandom_range(0, 31)), 12'($urandom_range(1900, 4095)));
            run_random(100);
        end
    endtask

    initial
    begin : status_sink
        clock_stat_t got;
        int          wait_cycles;
        status.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            wait_cycles = rx_idle ? $urandom_range(0, 10) : 0;
            wait_cycles += hold_cycles;
            hold_cycles = 0;
            if (wait_cycles > 0)
            begin
                status.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            status.ready <= 1'b1;
            do @(posedge clk); while (!status.valid);
            got.year = status.year_now;
            got.month = status.month_now;
            got.day = status.day_now;
            got.wday = status.weekday_now;
            got.hour = status.hour_now;
            got.minute = status.minute_now;
            got.second = status.second_now;
            got.fired = status.rollover;
            got.sunday = status.rollover_sunday;
            got.count = status.day_count;
            check_status(got);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (status.valid && status.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : run
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_ROLLOVER_HOUR;
        cfg_wdata <= '0;
        cmd.valid <= 1'b0;
        cmd.op <= OP_ADVANCE;
        cmd.advance_seconds <= '0;
        cmd.new_year <= '0;
        cmd.new_month <= '0;
        cmd.new_day <= '0;
        cmd.new_weekday <= '0;
        cmd.new_hour <= '0;
        cmd.new_minute <= '0;
        cmd.new_second <= '0;
        cal_year = YEAR_RST;
        cal_month = 4'd1;
        cal_day = 5'd1;
        cal_wday = 3'd0;
        cal_hour = 5'd0;
        cal_minute = 6'd0;
        cal_second = 6'd0;
        rollovers = 32'd0;
        roll_hour = ROLL_HR_RST;
        year_limit = MAX_YEAR_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_field_extremes();
        test_calendar_rollover();
        test_input_backpressure();
        test_config_sweep();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_status.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
